/* src/assert_macros.svh */
// Assertion macros used by the checker of the gradient operator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TGO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgo check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TGO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgo check failed: next-cycle rule");

`endif

/* src/tgo_pkg.sv */
// Types and widths shared by the tetrahedron gradient operator.
`default_nettype none
package tgo_pkg;

  localparam int FX_W   = 32;
  localparam int EDGE_W = 33;   // vertex difference
  localparam int PROD_W = 66;   // edge times edge
  localparam int COF_W  = 67;   // cofactor, Q35.32
  localparam int SUM_W  = 68;   // row sum of cofactors
  localparam int LO_W   = 34;   // unsigned low slice of a cofactor
  localparam int HI_W   = COF_W - LO_W;
  localparam int PLO_W  = EDGE_W + LO_W + 1;
  localparam int VOL_W  = 100;  // six-fold volume, Q52.48
  localparam int VMAG_W = 99;
  localparam int REM_W  = VMAG_W + 1;
  localparam int QB     = 34;   // quotient bits: one integer bit, 33 fraction bits
  localparam int LANES  = 4;

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  typedef logic signed [FX_W-1:0] fx_t;

  typedef struct packed {
    fx_t x0; fx_t y0; fx_t z0;
    fx_t x1; fx_t y1; fx_t z1;
    fx_t x2; fx_t y2; fx_t z2;
    fx_t x3; fx_t y3; fx_t z3;
  } in_word_t;

  typedef struct packed {
    logic [1:0] grad_row;
    fx_t        coef_v0;
    fx_t        coef_v1;
    fx_t        coef_v2;
    fx_t        coef_v3;
    logic       degenerate;
    logic       last_row;
  } out_word_t;

  // cof[3*row + col]
  typedef struct packed {
    logic [8:0][COF_W-1:0] cof;
    logic [2:0][SUM_W-1:0] rsum;
    logic [VOL_W-1:0]      vol;
  } front_word_t;

  // num[0] is the negated row sum, num[1..3] the row's cofactors
  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] num;
    logic [VOL_W-1:0]            vol;
    logic [1:0]                  row;
    logic                        last;
  } row_word_t;

endpackage
`default_nettype wire

/* src/tgo_if.sv */
// Valid/ready channel interfaces for the vertex and gradient words.
`default_nettype none
interface tgo_in_if;
  import tgo_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tgo_out_if;
  import tgo_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tgo_front.sv */
// Six-stage front: edges, cofactor products, cofactors, volume partials and row sums, volume terms, volume.
`default_nettype none
module tgo_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tgo_pkg::in_word_t    in_data,
  output logic                 in_ready,
  output logic                 fw_valid,
  output tgo_pkg::front_word_t fw_data,
  input  logic                 fw_ready
);
  import tgo_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [FX_W-1:0]   px [0:3], py [0:3], pz [0:3];
  logic signed [EDGE_W-1:0] ex_nxt [0:2], ey_nxt [0:2], ez_nxt [0:2];
  logic signed [EDGE_W-1:0] ex_r [0:2], ey_r [0:2], ez_r [0:2];
  logic signed [EDGE_W-1:0] ex2_r [0:2], ex3_r [0:2];
  logic signed [PROD_W-1:0] pa_nxt [0:8], pb_nxt [0:8], pa_r [0:8], pb_r [0:8];
  logic signed [COF_W-1:0]  cof_nxt [0:8], cof_r [0:8];
  logic signed [COF_W-1:0]  cof4_r [0:8], cof5_r [0:8], cof6_r [0:8];
  logic signed [PLO_W-1:0]  plo_nxt [0:2], plo_r [0:2];
  logic signed [PROD_W-1:0] phi_nxt [0:2], phi_r [0:2];
  logic [SUM_W-1:0]         rsum_nxt [0:2], rsum4_r [0:2], rsum5_r [0:2], rsum6_r [0:2];
  logic [VOL_W-1:0]         term_nxt [0:2], term_r [0:2];
  logic [VOL_W-1:0]         vol_nxt, vol_r;

  assign en       = !v6_r || fw_ready;
  assign in_ready = en;
  assign fw_valid = v6_r;

  assign px[0] = in_data.x0; assign py[0] = in_data.y0; assign pz[0] = in_data.z0;
  assign px[1] = in_data.x1; assign py[1] = in_data.y1; assign pz[1] = in_data.z1;
  assign px[2] = in_data.x2; assign py[2] = in_data.y2; assign pz[2] = in_data.z2;
  assign px[3] = in_data.x3; assign py[3] = in_data.y3; assign pz[3] = in_data.z3;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_col
      localparam int J = (gi + 1) % 3;
      localparam int K = (gi + 2) % 3;
      // edges from vertex 0
      assign ex_nxt[gi] = {px[gi+1][FX_W-1], px[gi+1]} - {px[0][FX_W-1], px[0]};
      assign ey_nxt[gi] = {py[gi+1][FX_W-1], py[gi+1]} - {py[0][FX_W-1], py[0]};
      assign ez_nxt[gi] = {pz[gi+1][FX_W-1], pz[gi+1]} - {pz[0][FX_W-1], pz[0]};
      // cofactor products, one pair per cofactor
      assign pa_nxt[gi]   = ey_r[J] * ez_r[K];
      assign pb_nxt[gi]   = ey_r[K] * ez_r[J];
      assign pa_nxt[3+gi] = ex_r[K] * ez_r[J];
      assign pb_nxt[3+gi] = ex_r[J] * ez_r[K];
      assign pa_nxt[6+gi] = ex_r[J] * ey_r[K];
      assign pb_nxt[6+gi] = ex_r[K] * ey_r[J];
      // volume partials against the first cofactor row, cofactor split in two slices
      assign plo_nxt[gi] = ex3_r[gi] * $signed({1'b0, cof_r[gi][LO_W-1:0]});
      assign phi_nxt[gi] = ex3_r[gi] * $signed(cof_r[gi][COF_W-1:LO_W]);
      assign rsum_nxt[gi] = {cof_r[3*gi][COF_W-1], cof_r[3*gi]}
                          + {cof_r[3*gi+1][COF_W-1], cof_r[3*gi+1]}
                          + {cof_r[3*gi+2][COF_W-1], cof_r[3*gi+2]};
      assign term_nxt[gi] = {phi_r[gi], {LO_W{1'b0}}}
                          + {{(VOL_W-PLO_W){plo_r[gi][PLO_W-1]}}, plo_r[gi]};
    end
    for (gi = 0; gi < 9; gi++) begin : g_cof
      assign cof_nxt[gi] = {pa_r[gi][PROD_W-1], pa_r[gi]} - {pb_r[gi][PROD_W-1], pb_r[gi]};
      assign fw_data.cof[gi] = cof6_r[gi];
    end
    for (gi = 0; gi < 3; gi++) begin : g_out
      assign fw_data.rsum[gi] = rsum6_r[gi];
    end
  endgenerate

  assign vol_nxt     = term_r[0] + term_r[1] + term_r[2];
  assign fw_data.vol = vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r;     v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ex_r[i]    <= ex_nxt[i];
        ey_r[i]    <= ey_nxt[i];
        ez_r[i]    <= ez_nxt[i];
        ex2_r[i]   <= ex_r[i];
        ex3_r[i]   <= ex2_r[i];
        plo_r[i]   <= plo_nxt[i];
        phi_r[i]   <= phi_nxt[i];
        rsum4_r[i] <= rsum_nxt[i];
        rsum5_r[i] <= rsum4_r[i];
        rsum6_r[i] <= rsum5_r[i];
        term_r[i]  <= term_nxt[i];
      end
      for (int i = 0; i < 9; i++) begin
        pa_r[i]   <= pa_nxt[i];
        pb_r[i]   <= pb_nxt[i];
        cof_r[i]  <= cof_nxt[i];
        cof4_r[i] <= cof_r[i];
        cof5_r[i] <= cof4_r[i];
        cof6_r[i] <= cof5_r[i];
      end
      vol_r <= vol_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tgo_row_seq.sv */
// Holds one tetrahedron and issues its three gradient rows in order.
`default_nettype none
module tgo_row_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fw_valid,
  input  tgo_pkg::front_word_t fw_data,
  output logic                 fw_ready,
  output logic                 row_valid,
  output tgo_pkg::row_word_t   row_data,
  input  logic                 row_ready
);
  import tgo_pkg::*;

  logic        hold_valid_r, hold_valid_nxt;
  logic [1:0]  row_r, row_nxt;
  front_word_t item_r;
  logic        take, final_row;
  logic [SUM_W-1:0] rs;
  logic [COF_W-1:0] c0, c1, c2;

  assign take      = hold_valid_r && row_ready;
  assign final_row = (row_r == ROW_Z);
  assign fw_ready  = !hold_valid_r || (take && final_row);
  assign row_valid = hold_valid_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    row_nxt        = row_r;
    if (fw_valid && fw_ready) begin
      hold_valid_nxt = 1'b1;
      row_nxt        = ROW_X;
    end else if (take && final_row) begin
      hold_valid_nxt = 1'b0;
    end else if (take) begin
      row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      row_r        <= ROW_X;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fw_valid && fw_ready) begin
      item_r <= fw_data;
    end
  end

  always_comb begin
    unique case (row_r)
      ROW_Y: begin
        rs = item_r.rsum[1]; c0 = item_r.cof[3]; c1 = item_r.cof[4]; c2 = item_r.cof[5];
      end
      ROW_Z: begin
        rs = item_r.rsum[2]; c0 = item_r.cof[6]; c1 = item_r.cof[7]; c2 = item_r.cof[8];
      end
      default: begin
        rs = item_r.rsum[0]; c0 = item_r.cof[0]; c1 = item_r.cof[1]; c2 = item_r.cof[2];
      end
    endcase
  end

  assign row_data.num[0] = {SUM_W{1'b0}} - rs;
  assign row_data.num[1] = {c0[COF_W-1], c0};
  assign row_data.num[2] = {c1[COF_W-1], c1};
  assign row_data.num[3] = {c2[COF_W-1], c2};
  assign row_data.vol    = item_r.vol;
  assign row_data.row    = row_r;
  assign row_data.last   = final_row;

endmodule
`default_nettype wire

/* src/tgo_div_pipe.sv */
// Four-lane restoring divider, one quotient bit per stage, with rounding and clamp.
`default_nettype none
module tgo_div_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               row_valid,
  input  tgo_pkg::row_word_t row_data,
  output logic               row_ready,
  output logic               out_valid,
  output tgo_pkg::out_word_t out_data,
  input  logic               out_ready
);
  import tgo_pkg::*;

  logic en;

  logic              v_r    [0:QB];
  logic [1:0]        row_r  [0:QB];
  logic              last_r [0:QB];
  logic              zero_r [0:QB];
  logic [VMAG_W-1:0] vmag_r [0:QB];
  logic [REM_W-1:0]  rem_r  [0:QB][0:LANES-1];
  logic [QB-1:0]     q_r    [0:QB][0:LANES-1];
  logic              neg_r  [0:QB][0:LANES-1];
  logic              sat_r  [0:QB][0:LANES-1];

  logic [VOL_W-1:0]  vabs;
  logic [VMAG_W-1:0] vmag_nxt;
  logic [REM_W-1:0]  rem0_nxt [0:LANES-1];
  logic              neg0_nxt [0:LANES-1];
  logic              sat0_nxt [0:LANES-1];
  logic [SUM_W-1:0]  nabs     [0:LANES-1];

  logic              out_valid_r;
  out_word_t         out_data_r, out_data_nxt;
  fx_t               coef     [0:LANES-1];

  assign en        = !out_valid_r || out_ready;
  assign row_ready = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // magnitudes, signs and early saturation
  always_comb begin
    vabs     = row_data.vol[VOL_W-1] ? ({VOL_W{1'b0}} - row_data.vol) : row_data.vol;
    vmag_nxt = vabs[VMAG_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      nabs[l] = row_data.num[l][SUM_W-1] ? ({SUM_W{1'b0}} - row_data.num[l])
                                         : row_data.num[l];
      rem0_nxt[l] = {{(REM_W-SUM_W+1){1'b0}}, nabs[l][SUM_W-2:0]};
      neg0_nxt[l] = row_data.num[l][SUM_W-1] ^ row_data.vol[VOL_W-1];
      sat0_nxt[l] = rem0_nxt[l] >= {vmag_nxt, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r[0]  <= row_data.row;
      last_r[0] <= row_data.last;
      zero_r[0] <= (vmag_nxt == {VMAG_W{1'b0}});
      vmag_r[0] <= vmag_nxt;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= rem0_nxt[l];
        q_r[0][l]   <= {QB{1'b0}};
        neg_r[0][l] <= neg0_nxt[l];
        sat_r[0][l] <= sat0_nxt[l];
      end
    end
  end

  genvar gk, gl;
  generate
    for (gk = 0; gk < QB; gk++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gk+1] <= 1'b0;
        end else if (en) begin
          v_r[gk+1] <= v_r[gk];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          row_r[gk+1]  <= row_r[gk];
          last_r[gk+1] <= last_r[gk];
          zero_r[gk+1] <= zero_r[gk];
          vmag_r[gk+1] <= vmag_r[gk];
        end
      end

      for (gl = 0; gl < LANES; gl++) begin : g_lane
        logic [REM_W-1:0] t;
        logic             ge;
        // integer bit first, then shift in one fraction bit per stage
        if (gk == 0) begin : g_int
          assign t = rem_r[gk][gl];
        end else begin : g_frac
          assign t = {rem_r[gk][gl][REM_W-2:0], 1'b0};
        end
        assign ge = t >= {1'b0, vmag_r[gk]};

        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[gk+1][gl] <= ge ? (t - {1'b0, vmag_r[gk]}) : t;
            q_r[gk+1][gl]   <= {q_r[gk][gl][QB-2:0], ge};
            neg_r[gk+1][gl] <= neg_r[gk][gl];
            sat_r[gk+1][gl] <= sat_r[gk][gl];
          end
        end
      end
    end
  endgenerate

  // round half away from zero, clamp, apply sign
  always_comb begin
    logic [QB:0]   qr;
    logic [QB-1:0] qh;
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic          negf;
    for (int l = 0; l < LANES; l++) begin
      qr   = {1'b0, q_r[QB][l]} + {{QB{1'b0}}, 1'b1};
      qh   = qr[QB:1];
      negf = neg_r[QB][l] && (sat_r[QB][l] || (qh != {QB{1'b0}}));
      lim  = negf ? {{(QB-FX_W){1'b0}}, 1'b1, {(FX_W-1){1'b0}}}
                  : {{(QB-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
      mag  = (sat_r[QB][l] || (qh > lim)) ? lim : qh;
      if (zero_r[QB]) begin
        coef[l] = '0;
      end else if (negf) begin
        coef[l] = {FX_W{1'b0}} - mag[FX_W-1:0];
      end else begin
        coef[l] = mag[FX_W-1:0];
      end
    end
    out_data_nxt.grad_row   = row_r[QB];
    out_data_nxt.coef_v0    = coef[0];
    out_data_nxt.coef_v1    = coef[1];
    out_data_nxt.coef_v2    = coef[2];
    out_data_nxt.coef_v3    = coef[3];
    out_data_nxt.degenerate = zero_r[QB];
    out_data_nxt.last_row   = last_r[QB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tetra_gradient_operator.sv */
// Top level of the linear tetrahedron gradient operator.
//
//  channel  dir  word        content
//  in_ch    in   in_word_t   four vertices x0..z3, signed Q16.16
//  out_ch   out  out_word_t  one gradient row: row index, four coefficients, flags
//
// One tetrahedron in, three words out (rows x, y, z, last_row on z).
// Sustained rate: one tetrahedron per three result words, set by the single result
// word per cycle of the output channel while out_ch.ready holds; the row sequencer
// takes a new tetrahedron while its last row moves on.
// From accepted input to the first row a word passes 6 front stages, the hold
// register of the row sequencer, 1 + 34 divider stages and the output register.
// Reset (rst_n low, synchronous) clears valid bits and the row counter only. A
// stall on out_ch freezes the divider pipe in place; the front keeps filling
// until its last stage holds a word, then drops in_ch.ready.
`default_nettype none
module tetra_gradient_operator (
  input  logic       clk,
  input  logic       rst_n,
  tgo_in_if.sink     in_ch,
  tgo_out_if.source  out_ch
);
  import tgo_pkg::*;

  // front -> row sequencer
  logic        fw_valid;
  logic        fw_ready;
  front_word_t fw_data;

  // row sequencer -> divider
  logic        row_valid;
  logic        row_ready;
  row_word_t   row_data;

  out_word_t   res_data;

  // Edges, nine cofactors, row sums and six-fold volume, fully pipelined.
  tgo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data),
    .in_ready (in_ch.ready),
    .fw_valid (fw_valid),
    .fw_data  (fw_data),
    .fw_ready (fw_ready)
  );

  // Hold one tetrahedron and issue rows x, y, z in order, each held until row_ready takes it.
  tgo_row_seq u_row_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fw_valid  (fw_valid),
    .fw_data   (fw_data),
    .fw_ready  (fw_ready),
    .row_valid (row_valid),
    .row_data  (row_data),
    .row_ready (row_ready)
  );

  // Four coefficients per row: restoring division by the volume, one bit a
  // stage, then round half away from zero and clamp to Q16.16. A zero volume
  // forces zero coefficients and raises degenerate.
  tgo_div_pipe u_div_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_data  (row_data),
    .row_ready (row_ready),
    .out_valid (out_ch.valid),
    .out_data  (res_data),
    .out_ready (out_ch.ready)
  );

  assign out_ch.data = res_data;

endmodule
`default_nettype wire

/* src/tgo_checker.sv */
// Port-level checks on the gradient row stream, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tgo_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          grad_row,
  input logic                degenerate,
  input logic                last_row,
  input tgo_pkg::fx_t        coef_v0,
  input tgo_pkg::fx_t        coef_v1,
  input tgo_pkg::fx_t        coef_v2,
  input tgo_pkg::fx_t        coef_v3
);
  import tgo_pkg::*;

  `TGO_ASSERT_SAME(a_last_on_z, out_valid && last_row, grad_row == ROW_Z)
  `TGO_ASSERT_SAME(a_mid_rows, out_valid && !last_row, grad_row == ROW_X || grad_row == ROW_Y)
  `TGO_ASSERT_SAME(a_degen_zero, out_valid && degenerate, coef_v0 == '0 && coef_v1 == '0 && coef_v2 == '0 && coef_v3 == '0)
  `TGO_ASSERT_NEXT(a_row_follows, out_valid && out_ready && !last_row, out_valid && grad_row == $past(grad_row) + 2'd1)
  `TGO_ASSERT_NEXT(a_degen_held, out_valid && out_ready && !last_row, degenerate == $past(degenerate))

endmodule

bind tetra_gradient_operator tgo_checker u_tgo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .grad_row   (out_ch.data.grad_row),
  .degenerate (out_ch.data.degenerate),
  .last_row   (out_ch.data.last_row),
  .coef_v0    (out_ch.data.coef_v0),
  .coef_v1    (out_ch.data.coef_v1),
  .coef_v2    (out_ch.data.coef_v2),
  .coef_v3    (out_ch.data.coef_v3)
);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the tetrahedron gradient operator.
`default_nettype none
module tb;
  import tgo_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   error_count;
  out_word_t gradient_rows_q[$];

  tgo_in_if  in_if();
  tgo_out_if out_if();

  tetra_gradient_operator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bound the run; any hang lands here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tetra_gradient_operator: mismatch");
      $finish;
    end
  end

  // Q16.16 quotient (num * 2^32) / vol, round half away from zero, saturate.
  function automatic fx_t gradient_coef(wide_t num, wide_t vol);
    logic [159:0] num_mag;
    logic [159:0] vol_mag;
    logic [159:0] quo;
    logic [159:0] rem;
    logic         neg;
    num_mag = {32'b0, (num < 0) ? -num : num} << 32;
    vol_mag = {32'b0, (vol < 0) ? -vol : vol};
    quo = num_mag / vol_mag;
    rem = num_mag % vol_mag;
    if ((rem << 1) >= vol_mag) quo = quo + 1;
    neg = ((num < 0) != (vol < 0)) && (quo != 0);
    if (neg) begin
      if (quo > 160'h8000_0000) quo = 160'h8000_0000;
      return fx_t'(-quo[31:0]);
    end else begin
      if (quo > 160'h7FFF_FFFF) quo = 160'h7FFF_FFFF;
      return fx_t'(quo[31:0]);
    end
  endfunction

  // Build the three expected gradient rows of one tetrahedron.
  task automatic predict_gradient(in_word_t w);
    wide_t ex[3], ey[3], ez[3];
    wide_t cof[3][3];
    wide_t vol, rsum;
    out_word_t row;
    logic [1:0] row_ids[3];
    row_ids[0] = ROW_X;
    row_ids[1] = ROW_Y;
    row_ids[2] = ROW_Z;
    ex[0] = wide_t'(w.x1) - wide_t'(w.x0);
    ey[0] = wide_t'(w.y1) - wide_t'(w.y0);
    ez[0] = wide_t'(w.z1) - wide_t'(w.z0);
    ex[1] = wide_t'(w.x2) - wide_t'(w.x0);
    ey[1] = wide_t'(w.y2) - wide_t'(w.y0);
    ez[1] = wide_t'(w.z2) - wide_t'(w.z0);
    ex[2] = wide_t'(w.x3) - wide_t'(w.x0);
    ey[2] = wide_t'(w.y3) - wide_t'(w.y0);
    ez[2] = wide_t'(w.z3) - wide_t'(w.z0);
    cof[0][0] = ey[1]*ez[2] - ey[2]*ez[1];
    cof[0][1] = ey[2]*ez[0] - ey[0]*ez[2];
    cof[0][2] = ey[0]*ez[1] - ey[1]*ez[0];
    cof[1][0] = ex[2]*ez[1] - ex[1]*ez[2];
    cof[1][1] = ex[0]*ez[2] - ex[2]*ez[0];
    cof[1][2] = ex[1]*ez[0] - ex[0]*ez[1];
    cof[2][0] = ex[1]*ey[2] - ex[2]*ey[1];
    cof[2][1] = ex[2]*ey[0] - ex[0]*ey[2];
    cof[2][2] = ex[0]*ey[1] - ex[1]*ey[0];
    vol = ex[0]*cof[0][0] + ex[1]*cof[0][1] + ex[2]*cof[0][2];
    for (int r = 0; r < 3; r++) begin
      row = '0;
      row.grad_row   = row_ids[r];
      row.degenerate = (vol == 0);
      row.last_row   = (r == 2);
      if (vol != 0) begin
        rsum = -(cof[r][0] + cof[r][1] + cof[r][2]);
        row.coef_v0 = gradient_coef(rsum, vol);
        row.coef_v1 = gradient_coef(cof[r][0], vol);
        row.coef_v2 = gradient_coef(cof[r][1], vol);
        row.coef_v3 = gradient_coef(cof[r][2], vol);
      end
      gradient_rows_q = {gradient_rows_q, row};
    end
  endtask

  // Drive one tetrahedron; hold valid until accepted, queue its rows.
  task automatic send_tetra(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    predict_gradient(w);
  endtask

  // Receiver stalls at random; settings change between phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted row word with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (gradient_rows_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_if.data);
        error_count++;
      end else begin
        out_word_t exp_row;
        exp_row = gradient_rows_q.pop_front();
        if (out_if.data.grad_row !== exp_row.grad_row)
          $display("%0t: grad_row exp %0d got %0d", $time, exp_row.grad_row,
                   out_if.data.grad_row);
        if (out_if.data.coef_v0 !== exp_row.coef_v0)
          $display("%0t: coef_v0 exp %h got %h", $time, exp_row.coef_v0,
                   out_if.data.coef_v0);
        if (out_if.data.coef_v1 !== exp_row.coef_v1)
          $display("%0t: coef_v1 exp %h got %h", $time, exp_row.coef_v1,
                   out_if.data.coef_v1);
        if (out_if.data.coef_v2 !== exp_row.coef_v2)
          $display("%0t: coef_v2 exp %h got %h", $time, exp_row.coef_v2,
                   out_if.data.coef_v2);
        if (out_if.data.coef_v3 !== exp_row.coef_v3)
          $display("%0t: coef_v3 exp %h got %h", $time, exp_row.coef_v3,
                   out_if.data.coef_v3);
        if (out_if.data.degenerate !== exp_row.degenerate)
          $display("%0t: degenerate exp %b got %b", $time, exp_row.degenerate,
                   out_if.data.degenerate);
        if (out_if.data.last_row !== exp_row.last_row)
          $display("%0t: last_row exp %b got %b", $time, exp_row.last_row,
                   out_if.data.last_row);
        if (out_if.data !== exp_row) error_count++;
      end
    end
  end

  function automatic in_word_t make_tetra(fx_t x0, fx_t y0, fx_t z0, fx_t x1, fx_t y1,
                                          fx_t z1, fx_t x2, fx_t y2, fx_t z2, fx_t x3,
                                          fx_t y3, fx_t z3);
    in_word_t w;
    w.x0 = x0; w.y0 = y0; w.z0 = z0;
    w.x1 = x1; w.y1 = y1; w.z1 = z1;
    w.x2 = x2; w.y2 = y2; w.z2 = z2;
    w.x3 = x3; w.y3 = y3; w.z3 = z3;
    return w;
  endfunction

  function automatic fx_t rand_fx();
    return fx_t'($urandom());
  endfunction

  function automatic fx_t rand_near(fx_t base, int span);
    return base + fx_t'($urandom_range(2*span) - span);
  endfunction

  // Zero volume: collapsed, repeated vertex and coplanar shapes.
  task automatic test_degenerate();
    localparam fx_t ONE = 32'sh0001_0000;
    send_tetra('0);
    send_tetra(make_tetra(0, 0, 0, ONE, 0, 0, ONE, 0, 0, 0, 0, ONE));
    send_tetra(make_tetra(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0));
    send_tetra('1);
  endtask

  // Unit shapes in both orientations and a few scaled ones.
  task automatic test_unit_shapes();
    localparam fx_t ONE = 32'sh0001_0000;
    send_tetra(make_tetra(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_tetra(make_tetra(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_tetra(make_tetra(ONE, ONE, ONE, 3*ONE, ONE, ONE, ONE, 4*ONE, ONE,
                          ONE, ONE, 7*ONE));
    send_tetra(make_tetra(0, 0, 0, 3, 0, 0, 0, 3, 0, 0, 0, 3));
    send_tetra(make_tetra(-ONE, -ONE, -ONE, 0, -ONE, -ONE, -ONE, 0, -ONE,
                          -ONE, -ONE, 0));
  endtask

  // Field extremes: huge edges, tiny edges forcing saturation.
  task automatic test_extremes();
    localparam fx_t MAXV = 32'sh7FFF_FFFF;
    localparam fx_t MINV = 32'sh8000_0000;
    send_tetra(make_tetra(MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV,
                          MINV, MINV, MAXV));
    send_tetra(make_tetra(MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MAXV,
                          MAXV, MAXV, MINV));
    send_tetra(make_tetra(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV,
                          MINV, MINV, MINV));
    send_tetra(make_tetra(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_tetra(make_tetra(0, 0, 0, -1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_tetra(make_tetra(MAXV, MAXV, MAXV, MAXV-1, MAXV, MAXV, MAXV, MAXV-1, MAXV,
                          MAXV, MAXV, MAXV-1));
    send_tetra(make_tetra(0, 0, 0, MAXV, 0, 0, 0, 1, 0, 0, 0, 1));
    send_tetra(make_tetra(0, 0, 0, 2, 1, 0, 1, 2, 0, 1, 1, 3));
  endtask

  // Mostly small well-shaped tetrahedra with random placement, plus
  // full-range noise, degenerate and nearly flat shapes.
  task automatic test_random(int n_items);
    in_word_t w;
    fx_t base_x, base_y, base_z;
    int span;
    for (int i = 0; i < n_items; i++) begin
      base_x = fx_t'($urandom_range(32'h7FFF_FFFF) - 32'h4000_0000);
      base_y = fx_t'($urandom_range(32'h7FFF_FFFF) - 32'h4000_0000);
      base_z = fx_t'($urandom_range(32'h7FFF_FFFF) - 32'h4000_0000);
      span = 1 << $urandom_range(24, 2);
      w = make_tetra(base_x, base_y, base_z,
                     rand_near(base_x, span), rand_near(base_y, span),
                     rand_near(base_z, span),
                     rand_near(base_x, span), rand_near(base_y, span),
                     rand_near(base_z, span),
                     rand_near(base_x, span), rand_near(base_y, span),
                     rand_near(base_z, span));
      case ($urandom_range(9))
        0, 1: begin
          w = make_tetra(rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                         rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                         rand_fx(), rand_fx());
        end
        2: begin
          // repeat a vertex
          w.x3 = w.x1; w.y3 = w.y1; w.z3 = w.z1;
        end
        3: begin
          // coplanar: fourth vertex in the plane of the others
          w.x3 = w.x1 + w.x2 - w.x0;
          w.y3 = w.y1 + w.y2 - w.y0;
          w.z3 = w.z1 + w.z2 - w.z0;
        end
        4: begin
          // nearly flat: volume tiny against the cofactors
          w.z3 = w.z0 + fx_t'($urandom_range(2));
          w.z1 = w.z0;
          w.z2 = w.z0 + fx_t'($urandom_range(1));
        end
        default: ;
      endcase
      send_tetra(w);
    end
  endtask

  task automatic set_idling(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    send_idle_pct  = 14;
    recv_stall_pct = 60;
    cycle_count    = 0;
    error_count    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(14, 60);
    test_degenerate();
    test_unit_shapes();
    test_extremes();
    test_random(38);

    set_idling(60, 14);
    test_random(38);

    set_idling(0, 0);
    test_random(38);

    in_if.valid <= 1'b0;
    while (gradient_rows_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (error_count == 0) begin
      $display("tetra_gradient_operator: match");
    end else begin
      $display("tetra_gradient_operator: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
